@@ hw/rtl/csc_pkg.sv @@
package csc_pkg;

  localparam int PAYLOAD_BYTES_DEF = 8;
  localparam int QUO_BITS          = 64;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ID  = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [2:0] REG_MESSAGE_ID     = 3'd0;
  localparam logic [2:0] REG_MESSAGE_LENGTH = 3'd1;
  localparam logic [2:0] REG_SIG_POS        = 3'd2;
  localparam logic [2:0] REG_BIT_COUNT      = 3'd3;
  localparam logic [2:0] REG_BIG_ENDIAN     = 3'd4;
  localparam logic [2:0] REG_SCALE_FACTOR   = 3'd5;
  localparam logic [2:0] REG_SCALE_OFFSET   = 3'd6;

  // one transaction as it travels down the divider row
  typedef struct packed {
    logic        vld;
    logic        op;
    logic [1:0]  status;
    logic        neg;
    logic [63:0] raw;
    logic [31:0] rem;
    logic [63:0] dvd;
  } csc_ctx_t;

  typedef struct packed {
    logic [3:0]         message_length;
    logic [5:0]         sig_pos;
    logic [6:0]         n;
    logic               big_endian;
    logic [31:0]        fmag;
    logic               fneg;
    logic signed [47:0] offset;
  } csc_cfg_t;

endpackage

@@ hw/rtl/can_signal_codec_top.sv @@
// Each transaction passes chain[0], the cell row and the csc_scale registers to the strobe.
// Throughput: one transaction per cycle; busy never rises.
// The encode quotient is formed by a row of 64 cells, one quotient bit per cell.
// Reset (rst_n low, synchronous) drops all transactions in flight and restores the
// register defaults. The receiver cannot stall; each result is shown for one cycle.
module can_signal_codec_top #(
  parameter int PAYLOAD_BYTES = csc_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [31:0]        in_frame_id,
  input  logic [3:0]         in_frame_length,
  input  logic [63:0]        in_frame_payload,
  input  logic signed [47:0] in_physical_in,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [63:0]        out_sig_raw,
  output logic signed [47:0] out_physical_out,
  output logic [63:0]        out_payload_out,
  output logic [3:0]         out_length_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_wdata
);

  localparam int LIMIT_BITS = ((PAYLOAD_BYTES > 8) ? 8 : PAYLOAD_BYTES) * 8;

  logic [31:0]        message_id_r;
  logic [3:0]         message_length_r;
  logic [5:0]         sig_pos_r;
  logic [6:0]         bit_count_r;
  logic               big_endian_r;
  logic signed [31:0] scale_factor_r;
  logic signed [47:0] scale_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      message_id_r     <= 32'd0;
      message_length_r <= 4'd8;
      sig_pos_r        <= 6'd0;
      bit_count_r      <= 7'd8;
      big_endian_r     <= 1'b0;
      scale_factor_r   <= 32'sd65536;
      scale_offset_r   <= 48'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        csc_pkg::REG_MESSAGE_ID:     message_id_r     <= cfg_wdata[31:0];
        csc_pkg::REG_MESSAGE_LENGTH: message_length_r <= cfg_wdata[3:0];
        csc_pkg::REG_SIG_POS:        sig_pos_r        <= cfg_wdata[5:0];
        csc_pkg::REG_BIT_COUNT:      bit_count_r      <= cfg_wdata[6:0];
        csc_pkg::REG_BIG_ENDIAN:     big_endian_r     <= cfg_wdata[0];
        csc_pkg::REG_SCALE_FACTOR:   scale_factor_r   <= cfg_wdata[31:0];
        csc_pkg::REG_SCALE_OFFSET:   scale_offset_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  csc_pkg::csc_cfg_t cfg;

  always_comb begin
    cfg.message_length = message_length_r;
    cfg.sig_pos        = sig_pos_r;
    cfg.n              = (bit_count_r > 7'd64) ? 7'd64 : bit_count_r;
    cfg.big_endian     = big_endian_r;
    cfg.fneg           = scale_factor_r[31];
    cfg.fmag           = scale_factor_r[31] ? (~scale_factor_r + 32'd1) : scale_factor_r;
    cfg.offset         = scale_offset_r;
  end

  assign busy = 1'b0;

  csc_pkg::csc_ctx_t front_nxt;
  csc_pkg::csc_ctx_t chain [0:csc_pkg::QUO_BITS];

  always_comb begin
    logic signed [48:0] diff;
    logic [47:0]        dmag;
    logic [7:0]         pos;
    diff = {in_physical_in[47], in_physical_in} - {scale_offset_r[47], scale_offset_r};
    dmag = diff[48] ? 48'(-diff) : diff[47:0];
    front_nxt.vld = start && !busy && rst_n;
    front_nxt.op  = in_opcode;
    front_nxt.neg = diff[48] ^ scale_factor_r[31];
    front_nxt.rem = 32'd0;
    front_nxt.dvd = {dmag, 16'd0};
    if (in_frame_id != message_id_r) begin
      front_nxt.status = csc_pkg::ST_BAD_ID;
    end else if (in_opcode == csc_pkg::OP_DECODE && in_frame_length != message_length_r) begin
      front_nxt.status = csc_pkg::ST_BAD_LEN;
    end else if (in_opcode == csc_pkg::OP_ENCODE && scale_factor_r == 32'sd0) begin
      front_nxt.status = csc_pkg::ST_RANGE;
    end else begin
      front_nxt.status = csc_pkg::ST_OK;
    end
    front_nxt.raw = 64'd0;
    for (int i = 0; i < 64; i++) begin
      if (big_endian_r) begin
        pos = {2'b0, sig_pos_r} + {1'b0, cfg.n} - 8'd1 - 8'(i);
        pos = {pos[7:3], ~pos[2:0]};
      end else begin
        pos = {2'b0, sig_pos_r} + 8'(i);
      end
      if (7'(i) < cfg.n && pos < 8'(LIMIT_BITS)) begin
        front_nxt.raw[i] = in_frame_payload[pos[5:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    chain[0] <= front_nxt;
  end

  for (genvar g = 0; g < csc_pkg::QUO_BITS; g++) begin : g_cell
    csc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .fmag    (cfg.fmag),
      .ctx_in  (chain[g]),
      .ctx_out (chain[g+1])
    );
  end

  csc_scale #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctx_in           (chain[csc_pkg::QUO_BITS]),
    .cfg              (cfg),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_sig_raw      (out_sig_raw),
    .out_physical_out (out_physical_out),
    .out_payload_out  (out_payload_out),
    .out_length_out   (out_length_out)
  );

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != csc_pkg::ST_OK |->
      out_sig_raw == 64'd0 && out_physical_out == 48'sd0 && out_payload_out == 64'd0)
    else $error("failed transaction carries data");

  a_word_from_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_payload_out != 64'd0 |-> out_sig_raw != 64'd0)
    else $error("payload bits without quotient");

  a_enc_no_phys: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_payload_out != 64'd0 |-> out_physical_out == 48'sd0)
    else $error("encode result with physical value");

endmodule

@@ hw/rtl/csc_cell.sv @@
module csc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       fmag,
  input  csc_pkg::csc_ctx_t ctx_in,
  output csc_pkg::csc_ctx_t ctx_out
);

  csc_pkg::csc_ctx_t ctx_r, ctx_nxt;
  logic [32:0] r2;
  logic        ge;

  always_comb begin
    r2 = {ctx_in.rem, ctx_in.dvd[63]};
    ge = (r2 >= {1'b0, fmag});
    ctx_nxt = ctx_in;
    ctx_nxt.vld = ctx_in.vld && rst_n;
    ctx_nxt.rem = ge ? 32'(r2 - {1'b0, fmag}) : r2[31:0];
    ctx_nxt.dvd = {ctx_in.dvd[62:0], ge};
  end

  always_ff @(posedge clk) begin
    ctx_r <= ctx_nxt;
  end

  assign ctx_out = ctx_r;

endmodule

@@ hw/rtl/csc_scale.sv @@
module csc_scale #(
  parameter int PAYLOAD_BYTES = csc_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csc_pkg::csc_ctx_t  ctx_in,
  input  csc_pkg::csc_cfg_t  cfg,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [63:0]        out_sig_raw,
  output logic signed [47:0] out_physical_out,
  output logic [63:0]        out_payload_out,
  output logic [3:0]         out_length_out
);

  localparam int LIMIT_BITS = ((PAYLOAD_BYTES > 8) ? 8 : PAYLOAD_BYTES) * 8;

  localparam logic signed [51:0] PMAX52 = 52'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [51:0] PMIN52 = -52'sh0_8000_0000_0000;
  localparam logic [95:0]        SAT_LIM = 96'h4_0000_0000_0000;

  logic        a_vld_r;
  logic        a_op_r;
  logic [1:0]  a_status_r, a_status_nxt;
  logic [63:0] a_raw_r, a_raw_nxt;
  logic [63:0] a_word_r, a_word_nxt;
  logic [63:0] a_plo_r, a_phi_r;

  always_comb begin
    logic [6:0] pp;
    logic [6:0] k;
    logic [6:0] idx;
    a_raw_nxt    = ctx_in.op ? ctx_in.dvd : ctx_in.raw;
    a_status_nxt = ctx_in.status;
    if (ctx_in.op == csc_pkg::OP_ENCODE && ctx_in.status == csc_pkg::ST_OK &&
        ctx_in.neg && ctx_in.dvd != 64'd0) begin
      a_status_nxt = csc_pkg::ST_RANGE;
    end
    a_word_nxt = 64'd0;
    for (int p = 0; p < 64; p++) begin
      pp = 7'(p);
      if (cfg.big_endian) begin
        pp = {pp[6:3], ~pp[2:0]};
      end
      k   = pp - {1'b0, cfg.sig_pos};
      idx = cfg.big_endian ? (cfg.n - 7'd1 - k) : k;
      if (p < LIMIT_BITS && pp >= {1'b0, cfg.sig_pos} && k < cfg.n) begin
        a_word_nxt[p] = ctx_in.dvd[idx[5:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= ctx_in.vld;
    end
    a_op_r     <= ctx_in.op;
    a_status_r <= a_status_nxt;
    a_raw_r    <= a_raw_nxt;
    a_word_r   <= a_word_nxt;
    a_plo_r    <= ctx_in.raw[31:0]  * cfg.fmag;
    a_phi_r    <= ctx_in.raw[63:32] * cfg.fmag;
  end

  logic [95:0]        prod;
  logic signed [51:0] sum;
  logic signed [47:0] phys;
  logic               strobe_r;
  logic [1:0]         status_r;
  logic [63:0]        raw_r, payload_r;
  logic signed [47:0] phys_r;
  logic [3:0]         len_r;

  always_comb begin
    prod = {a_phi_r, 32'd0} + {32'd0, a_plo_r};
    sum  = cfg.fneg ? (52'(cfg.offset) - $signed({1'b0, prod[50:0]}))
                    : (52'(cfg.offset) + $signed({1'b0, prod[50:0]}));
    if (prod > SAT_LIM) begin
      phys = cfg.fneg ? PMIN52[47:0] : PMAX52[47:0];
    end else if (sum > PMAX52) begin
      phys = PMAX52[47:0];
    end else if (sum < PMIN52) begin
      phys = PMIN52[47:0];
    end else begin
      phys = sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= a_vld_r;
    end
    status_r <= a_status_r;
    if (a_status_r == csc_pkg::ST_OK) begin
      raw_r <= a_raw_r;
      if (a_op_r == csc_pkg::OP_ENCODE) begin
        phys_r    <= 48'sd0;
        payload_r <= a_word_r;
        len_r     <= cfg.message_length;
      end else begin
        phys_r    <= phys;
        payload_r <= 64'd0;
        len_r     <= 4'd0;
      end
    end else begin
      raw_r     <= 64'd0;
      phys_r    <= 48'sd0;
      payload_r <= 64'd0;
      len_r     <= 4'd0;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_sig_raw      = raw_r;
  assign out_physical_out = phys_r;
  assign out_payload_out  = payload_r;
  assign out_length_out   = len_r;

endmodule
